[src/bed_pkg.sv]
// ---------------------------------------------------------------------------
// bed_pkg - shared types and constants
// Pixel and window types, register map and sizing defaults for the 3x3
// binary erode/dilate block.
// ---------------------------------------------------------------------------
package bed_pkg;

    localparam int PIX_W          = 8;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam int FW_W   = 11;   // frame_width register
    localparam int FH_W   = 13;   // frame_height register
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [FW_W-1:0] RST_FRAME_WIDTH  = 11'd1024;
    localparam logic [FH_W-1:0] RST_FRAME_HEIGHT = 13'd4096;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_ERODE  = 2'd0;
    localparam logic [1:0] REG_EIGHT  = 2'd1;
    localparam logic [1:0] REG_WIDTH  = 2'd2;
    localparam logic [1:0] REG_HEIGHT = 2'd3;

    typedef logic [PIX_W-1:0] pixel_t;

    // one line store word: previous row and the row before it
    typedef struct packed {
        pixel_t near_row;
        pixel_t far_row;
    } bed_lines_t;

    // one window column, top to bottom
    typedef struct packed {
        pixel_t top;
        pixel_t mid;
        pixel_t bot;
    } bed_column_t;

    // neighbours to ignore, outside the image
    typedef struct packed {
        logic top;
        logic bot;
        logic lft;
        logic rgt;
    } bed_border_t;

    typedef struct packed {
        logic erode_mode;
        logic eight_connected;
    } bed_mode_t;

endpackage

[src/bed_if.sv]
// ---------------------------------------------------------------------------
// bed_in_if / bed_out_if - valid/ready stream channels
// Input channel carries pixel or flush transfers, output channel carries
// processed pixels with an end-of-frame flag.
// ---------------------------------------------------------------------------
interface bed_in_if
    import bed_pkg::*;
();
    logic   valid;
    logic   ready;
    logic   func;
    pixel_t pixel_in;

    modport source (output valid, output func, output pixel_in, input ready);
    modport sink   (input valid, input func, input pixel_in, output ready);
endinterface

interface bed_out_if
    import bed_pkg::*;
();
    logic   valid;
    logic   ready;
    pixel_t pixel_out;
    logic   frame_done;

    modport source (output valid, output pixel_out, output frame_done, input ready);
    modport sink   (input valid, input pixel_out, input frame_done, output ready);
endinterface

[src/bed_line_buf.sv]
// ---------------------------------------------------------------------------
// bed_line_buf - two-row line store
// One word per column holding the last two rows; registered read port.
// ---------------------------------------------------------------------------
module bed_line_buf
    import bed_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_WIDTH,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output bed_lines_t    rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  bed_lines_t    wr_data
);

    bed_lines_t mem [DEPTH];
    bed_lines_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/bed_kernel.sv]
// ---------------------------------------------------------------------------
// bed_kernel - 3x3 window and neighbour decision
// Shifts one column in per step and decides the centre pixel of the
// shifted window.
// ---------------------------------------------------------------------------
module bed_kernel
    import bed_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        shift,
    input  bed_column_t col_in,
    input  bed_border_t border,
    input  bed_mode_t   mode,
    output pixel_t      result
);

    bed_column_t win_reg [3];   // 0 left, 1 centre, 2 right
    bed_column_t win_next [3];
    pixel_t      fg;
    pixel_t      bg;
    pixel_t      centre;
    logic        hit;

    always_comb
    begin
        win_next[0] = win_reg[1];
        win_next[1] = win_reg[2];
        win_next[2] = col_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg[0] <= '0;
            win_reg[1] <= '0;
            win_reg[2] <= '0;
        end
        else if (shift)
        begin
            win_reg[0] <= win_next[0];
            win_reg[1] <= win_next[1];
            win_reg[2] <= win_next[2];
        end
    end

    // dilate: f=1 b=0, erode: f=0 b=1
    assign fg     = {{(PIX_W-1){1'b0}}, ~mode.erode_mode};
    assign bg     = {{(PIX_W-1){1'b0}}, mode.erode_mode};
    assign centre = win_next[1].mid;

    always_comb
    begin
        hit = 1'b0;
        if (!border.top && win_next[1].top == fg) hit = 1'b1;
        if (!border.bot && win_next[1].bot == fg) hit = 1'b1;
        if (!border.lft && win_next[0].mid == fg) hit = 1'b1;
        if (!border.rgt && win_next[2].mid == fg) hit = 1'b1;
        if (mode.eight_connected)
        begin
            if (!border.top && !border.lft && win_next[0].top == fg) hit = 1'b1;
            if (!border.top && !border.rgt && win_next[2].top == fg) hit = 1'b1;
            if (!border.bot && !border.lft && win_next[0].bot == fg) hit = 1'b1;
            if (!border.bot && !border.rgt && win_next[2].bot == fg) hit = 1'b1;
        end
        result = (centre == bg && hit) ? fg : centre;
    end

endmodule

[src/binary_erode_dilate_2d.sv]
// ---------------------------------------------------------------------------
// binary_erode_dilate_2d - streaming 3x3 binary erosion / dilation
// Line-buffered window, one pixel transfer per clock if unstalled, APB register port.
// ---------------------------------------------------------------------------
// Usage
//   pix_in takes one transfer per clock: func=0 carries a pixel in row
//   order, func=1 is a flush tick. Results leave on pix_out in row order,
//   trailing the input by one row plus one pixel; after the last pixel of
//   a frame, w+1 further transfers (flush ticks, or pixels, which are then
//   dropped) drain the tail. frame_done marks the last pixel of a frame.
//   Path: the transfer that completes a result's neighbourhood loads the
//   input register, then the output register, which drives pix_out.
//   Throughput: one transfer per clock while unstalled, set by the single
//   write per clock on the line store (one word per column).
//   Receiver stall: the output register holds its result; one more item
//   sits in the input register, and ready drops only while both are full
//   and pix_out.ready is low. Items that make no result never block.
//   Reset: registers to their defaults, position counters and window to zero;
//   the line store is not cleared, no result uses an unwritten word. Size
//   register writes restart the frame; the user must write while idle, unchecked.
// ---------------------------------------------------------------------------
module binary_erode_dilate_2d
    import bed_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    bed_in_if.sink            pix_in,
    bed_out_if.source         pix_out
);

    localparam int CW = $clog2(MAX_WIDTH);        // column index
    localparam int WW = $clog2(MAX_WIDTH + 1);    // width value
    localparam int RW = $clog2(MAX_HEIGHT + 2);   // row, runs to height+1 in drain

    // ---------------- configuration ----------------
    logic            erode_mode_reg;
    logic            eight_conn_reg;
    logic [FW_W-1:0] frame_width_reg;
    logic [FH_W-1:0] frame_height_reg;
    logic [1:0]      reg_idx;
    logic            cfg_wr;
    logic            size_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_AW-1:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign size_wr = cfg_wr && (reg_idx == REG_WIDTH || reg_idx == REG_HEIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            erode_mode_reg   <= 1'b0;
            eight_conn_reg   <= 1'b1;
            frame_width_reg  <= RST_FRAME_WIDTH;
            frame_height_reg <= RST_FRAME_HEIGHT;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_ERODE:  erode_mode_reg   <= pwdata[0];
                REG_EIGHT:  eight_conn_reg   <= pwdata[0];
                REG_WIDTH:  frame_width_reg  <= pwdata[FW_W-1:0];
                REG_HEIGHT: frame_height_reg <= pwdata[FH_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_ERODE:  prdata = APB_DW'(erode_mode_reg);
            REG_EIGHT:  prdata = APB_DW'(eight_conn_reg);
            REG_WIDTH:  prdata = APB_DW'(frame_width_reg);
            REG_HEIGHT: prdata = APB_DW'(frame_height_reg);
        endcase
    end

    // effective sizes, saturated to the supported range
    logic [WW-1:0] eff_w;
    logic [RW-1:0] eff_h;

    always_comb
    begin
        if (frame_width_reg < FW_W'(2))
            eff_w = WW'(2);
        else if (32'(frame_width_reg) > 32'(MAX_WIDTH))
            eff_w = WW'(MAX_WIDTH);
        else
            eff_w = WW'(frame_width_reg);

        if (frame_height_reg < FH_W'(2))
            eff_h = RW'(2);
        else if (32'(frame_height_reg) > 32'(MAX_HEIGHT))
            eff_h = RW'(MAX_HEIGHT);
        else
            eff_h = RW'(frame_height_reg);
    end

    // ---------------- position of the next item ----------------
    // Rows at or past the height are the drain: each transfer there
    // stands for a pixel below the image, so the window keeps moving.
    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    logic          draining;
    logic          advance;
    logic          accept;
    logic          load_a;
    logic          col_zero;
    logic          last_col;
    logic          emit_d;
    logic          done_d;
    bed_border_t   border_d;

    assign draining = row_reg >= eff_h;
    assign advance  = !pix_in.func || draining;
    assign accept   = pix_in.valid && pix_in.ready;
    assign load_a   = accept && advance;     // plain flush ticks mid-frame do nothing
    assign col_zero = col_reg == '0;
    assign last_col = WW'(col_reg) == (eff_w - WW'(1));

    // window centre sits one row plus one pixel behind the item
    always_comb
    begin
        emit_d = (row_reg >= RW'(2)) || (row_reg == RW'(1) && !col_zero);
        if (col_zero)
        begin
            // centre is the last pixel of the row before last
            border_d.top = row_reg == RW'(2);
            border_d.bot = row_reg == (eff_h + RW'(1));
            border_d.lft = 1'b0;
            border_d.rgt = 1'b1;
        end
        else
        begin
            border_d.top = row_reg == RW'(1);
            border_d.bot = row_reg == eff_h;
            border_d.lft = col_reg == CW'(1);
            border_d.rgt = 1'b0;
        end
        done_d = col_zero && row_reg == (eff_h + RW'(1));
    end

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (size_wr)
        begin
            row_next = '0;
            col_next = '0;
        end
        else if (load_a)
        begin
            if (done_d)
            begin
                row_next = '0;
                col_next = '0;
            end
            else if (last_col)
            begin
                row_next = row_reg + RW'(1);
                col_next = '0;
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // ---------------- input register ----------------
    logic          a_valid_reg;
    logic          a_emit_reg;
    logic          a_done_reg;
    logic          a_write_reg;
    pixel_t        a_pixel_reg;
    logic [CW-1:0] a_col_reg;
    bed_border_t   a_border_reg;
    logic          a_adv;
    logic          o_valid_reg;
    pixel_t        o_pixel_reg;
    logic          o_done_reg;

    assign a_adv        = a_valid_reg && (!a_emit_reg || !o_valid_reg || pix_out.ready);
    assign pix_in.ready = !a_valid_reg || a_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (load_a)
            a_valid_reg <= 1'b1;
        else if (a_adv)
            a_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_a)
        begin
            a_emit_reg   <= emit_d;
            a_done_reg   <= done_d;
            a_write_reg  <= !draining;
            a_pixel_reg  <= pix_in.pixel_in;
            a_col_reg    <= col_reg;
            a_border_reg <= border_d;
        end
    end

    // ---------------- line store and window ----------------
    // Read at load, write back as the item leaves the input register; a column
    // comes round again only after at least two items, so no bypass is needed.
    bed_lines_t  lines_rd;
    bed_lines_t  lines_wr;
    bed_column_t col_in;
    bed_mode_t   mode;
    pixel_t      result;

    assign lines_wr.near_row = a_pixel_reg;
    assign lines_wr.far_row  = lines_rd.near_row;

    bed_line_buf #(
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .clk     (clk),
        .rd_en   (load_a),
        .rd_addr (col_reg),
        .rd_data (lines_rd),
        .wr_en   (a_adv && a_write_reg),
        .wr_addr (a_col_reg),
        .wr_data (lines_wr)
    );

    assign col_in.top           = lines_rd.far_row;
    assign col_in.mid           = lines_rd.near_row;
    assign col_in.bot           = a_pixel_reg;
    assign mode.erode_mode      = erode_mode_reg;
    assign mode.eight_connected = eight_conn_reg;

    bed_kernel u_kernel (
        .clk    (clk),
        .rst_n  (rst_n),
        .shift  (a_adv),
        .col_in (col_in),
        .border (a_border_reg),
        .mode   (mode),
        .result (result)
    );

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else if (a_adv && a_emit_reg)
            o_valid_reg <= 1'b1;
        else if (pix_out.ready)
            o_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (a_adv && a_emit_reg)
        begin
            o_pixel_reg <= result;
            o_done_reg  <= a_done_reg;
        end
    end

    assign pix_out.valid      = o_valid_reg;
    assign pix_out.pixel_out  = o_pixel_reg;
    assign pix_out.frame_done = o_done_reg;

endmodule

[src/bed_checker.sv]
// ---------------------------------------------------------------------------
// bed_checker - port-level checks
// Stall behaviour and result timing seen at the channel ports.
// ---------------------------------------------------------------------------
module bed_checker
    import bed_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    input logic   in_valid,
    input logic   in_ready,
    input logic   out_valid,
    input logic   out_ready,
    input pixel_t out_pixel,
    input logic   out_done
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_pixel) && $stable(out_done))
    else $error("stalled result changed");

    // input backs up only behind a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
    else $error("input not ready without output stall");

    // a fresh result follows an input transfer through the input and output registers
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a matching input transfer");

endmodule

bind binary_erode_dilate_2d bed_checker u_bed_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pix_in.valid),
    .in_ready  (pix_in.ready),
    .out_valid (pix_out.valid),
    .out_ready (pix_out.ready),
    .out_pixel (pix_out.pixel_out),
    .out_done  (pix_out.frame_done)
);

[verif/bed_morph_checker.sv]
// ---------------------------------------------------------------------------
// bed_morph_checker - result predictor and comparator
// Watches the register port and both stream channels, keeps its own model
// of the 3x3 erode/dilate pass and checks every output transfer in order.
// ---------------------------------------------------------------------------
module bed_morph_checker
    import bed_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    bed_in_if                 pin,
    bed_out_if                pout,
    output int                fail_count,
    output int                pending
);

    localparam int HIST_DEPTH = 2 * DEF_MAX_WIDTH + 4;
    localparam int MAX_LINES  = 30;

    typedef struct packed {
        pixel_t pixel;
        logic   done;
    } morph_result_t;

    // register copies
    logic            erode_q;
    logic            eight_q;
    logic [FW_W-1:0] width_q;
    logic [FH_W-1:0] height_q;

    // received pixels of the current frame, and position counters
    pixel_t          history [HIST_DEPTH];
    int unsigned     n_rcvd;
    int unsigned     n_sent;
    morph_result_t   due_results [$];

    task automatic report_mismatch(input string what);
        if (fail_count < MAX_LINES)
            $display("[%0t] ERROR: %s", $realtime, what);
        fail_count++;
    endtask

    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
        if (v < 2)
            return 2;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // one input transfer through the erode/dilate pass; may queue one result
    function automatic void morph_step(input logic is_flush, input pixel_t pix);
        int unsigned   cols;
        int unsigned   rows;
        int unsigned   total;
        int unsigned   p;
        int unsigned   r;
        int unsigned   c;
        int            q;
        int            dr;
        int            dc;
        pixel_t        fg;
        pixel_t        bg;
        pixel_t        centre;
        pixel_t        res;
        morph_result_t item;
        cols  = clamp_dim(width_q, DEF_MAX_WIDTH);
        rows  = clamp_dim(height_q, DEF_MAX_HEIGHT);
        total = cols * rows;
        if (n_rcvd > total || n_sent >= total)
        begin
            n_rcvd = 0;
            n_sent = 0;
        end
        // pixels after the frame end are dropped, acting as flush ticks
        if (!is_flush && n_rcvd < total)
        begin
            history[n_rcvd % HIST_DEPTH] = pix;
            n_rcvd++;
        end
        p = n_sent;
        if (n_rcvd != total && n_rcvd < p + cols + 2)
            return;
        r      = p / cols;
        c      = p % cols;
        fg     = erode_q ? pixel_t'(0) : pixel_t'(1);
        bg     = erode_q ? pixel_t'(1) : pixel_t'(0);
        centre = history[p % HIST_DEPTH];
        res    = centre;
        for (dr = -1; dr <= 1; dr++)
        begin
            for (dc = -1; dc <= 1; dc++)
            begin
                if (dr == 0 && dc == 0)
                    continue;
                if ((dr < 0 && r == 0) || (dr > 0 && r + 1 >= rows))
                    continue;
                if ((dc < 0 && c == 0) || (dc > 0 && c + 1 >= cols))
                    continue;
                if (dr != 0 && dc != 0 && !eight_q)
                    continue;
                q = int'(p) + dr * int'(cols) + dc;
                if (centre == bg && history[q % HIST_DEPTH] == fg)
                    res = fg;
            end
        end
        item.pixel = res;
        item.done  = (p + 1 == total);
        due_results.push_back(item);
        n_sent++;
        if (n_sent >= total)
        begin
            n_rcvd = 0;
            n_sent = 0;
        end
    endfunction

    // everything is sampled at the falling clock edge, ahead of the rising edge that moves it
    always @(negedge clk or negedge rst_n)
    begin
        morph_result_t want;
        if (!rst_n)
        begin
            erode_q    = 1'b0;
            eight_q    = 1'b1;
            width_q    = RST_FRAME_WIDTH;
            height_q   = RST_FRAME_HEIGHT;
            n_rcvd     = 0;
            n_sent     = 0;
            fail_count = 0;
            due_results.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_ERODE:  erode_q = pwdata[0];
                    REG_EIGHT:  eight_q = pwdata[0];
                    REG_WIDTH:
                    begin
                        width_q = pwdata[FW_W-1:0];
                        n_rcvd  = 0;
                        n_sent  = 0;
                    end
                    REG_HEIGHT:
                    begin
                        height_q = pwdata[FH_W-1:0];
                        n_rcvd   = 0;
                        n_sent   = 0;
                    end
                    default: ;
                endcase
            end
            if (pin.valid && pin.ready)
                morph_step(pin.func, pin.pixel_in);
            if (pout.valid && pout.ready)
            begin
                if (due_results.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result pixel %0d done %0d",
                                              pout.pixel_out, pout.frame_done));
                end
                else
                begin
                    want = due_results.pop_front();
                    if (pout.pixel_out !== want.pixel)
                        report_mismatch($sformatf("pixel_out %0d, want %0d",
                                                  pout.pixel_out, want.pixel));
                    if (pout.frame_done !== want.done)
                        report_mismatch($sformatf("frame_done %0d, want %0d",
                                                  pout.frame_done, want.done));
                end
            end
        end
        pending = due_results.size();
    end

endmodule

[verif/tb_binary_erode_dilate_2d.sv]
// ---------------------------------------------------------------------------
// tb_binary_erode_dilate_2d - top level of the erode/dilate testbench
// Drives register writes and pixel/flush transfers with random pacing on
// both channels; the checker beside the block predicts and compares.
// ---------------------------------------------------------------------------
module tb_binary_erode_dilate_2d;
    import bed_pkg::*;

    // input transfer kinds
    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_FLUSH = 1'b1;

    // pixel content styles for a frame
    localparam int STY_BINARY = 0;   // 0/1 with a random density
    localparam int STY_BLANKS = 1;   // mostly 0/1, some other values
    localparam int STY_ANY    = 2;   // full byte range
    localparam int STY_FLAT   = 3;   // every pixel the same 0 or 1

    localparam int ITEM_TARGET  = 230;    // random small frames
    localparam int WIDE_CUT     = 1080;   // pixels of the widest frame
    localparam int CYCLE_LIMIT  = 1500000;
    localparam int SETTLE       = 4;    // input reg + output reg, with margin

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int                fail_count;
    int                pending;
    int                cycle_count = 0;
    int                items_sent  = 0;
    int                src_calm    = 0;

    bed_in_if  pix_in_ch ();
    bed_out_if pix_out_ch ();

    binary_erode_dilate_2d DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .pix_in  (pix_in_ch),
        .pix_out (pix_out_ch)
    );

    bed_morph_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pin        (pix_in_ch),
        .pout       (pix_out_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #4 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // idle length: mostly short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 8);
        return $urandom_range(20, 40);
    endfunction

    // sender pacing, with calm stretches that never idle
    function automatic int sender_gap();
        int r;
        if (src_calm > 0)
        begin
            src_calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            src_calm = $urandom_range(30, 150);
            return 0;
        end
        if (r < 25)
            return pick_gap();
        return 0;
    endfunction

    // receiver pacing: stalls of random length and stall-free stretches
    initial
    begin : sink_pace
        int hold;
        int calm;
        int r;
        hold = 0;
        calm = 0;
        pix_out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                hold--;
                pix_out_ch.ready <= 1'b0;
            end
            else if (calm > 0)
            begin
                calm--;
                pix_out_ch.ready <= 1'b1;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 4)
                begin
                    calm = $urandom_range(30, 150);
                    pix_out_ch.ready <= 1'b1;
                end
                else if (r < 30)
                begin
                    hold = pick_gap() - 1;
                    pix_out_ch.ready <= 1'b0;
                end
                else
                    pix_out_ch.ready <= 1'b1;
            end
        end
    end

    // APB write: setup then access; lands on the edge with pready high,
    // after which the bus goes idle
    task automatic reg_write(input logic [1:0] idx, input logic [APB_DW-1:0] value);
        bit done;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(negedge clk);
            done = pready;
            @(posedge clk);
        end
        while (!done);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // one input transfer, after a random idle gap
    task automatic push_item(input logic fn, input pixel_t value);
        int gap;
        bit took;
        gap = sender_gap();
        if (gap > 0)
        begin
            pix_in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_in_ch.valid    <= 1'b1;
        pix_in_ch.func     <= fn;
        pix_in_ch.pixel_in <= value;
        // ready is settled by the falling edge; the transfer is at the next rise
        do
        begin
            @(negedge clk);
            took = pix_in_ch.ready;
            @(posedge clk);
        end
        while (!took);
        items_sent++;
    endtask

    // hold off until every predicted result has left, then let the pipe empty
    task automatic wait_idle();
        pix_in_ch.valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic pixel_t pick_pixel(input int style, input int density);
        case (style)
            STY_BINARY: return ($urandom_range(0, 99) < density) ? 8'd1 : 8'd0;
            STY_BLANKS:
            begin
                if ($urandom_range(0, 99) < 15)
                    return ($urandom_range(0, 3) == 0) ? 8'd255 : pixel_t'($urandom_range(2, 255));
                return ($urandom_range(0, 99) < density) ? 8'd1 : 8'd0;
            end
            STY_ANY:    return pixel_t'($urandom_range(0, 255));
            default:    return (density >= 50) ? 8'd1 : 8'd0;
        endcase
    endfunction

    // One frame of cols x rows pixels with the tail drained by w+1 transfers.
    // A non-zero cut stops after that many pixels and leaves the frame open.
    task automatic stream_frame(input int cols, input int rows, input int style, input int cut);
        int n_pix;
        int density;
        int i;
        n_pix   = (cut > 0) ? cut : cols * rows;
        density = $urandom_range(0, 100);
        for (i = 0; i < n_pix; i++)
        begin
            // stray flush mid-frame: nothing is ready, so no result
            if ($urandom_range(0, 99) < 4)
                push_item(FUNC_FLUSH, pixel_t'($urandom_range(0, 255)));
            // occasional mid-frame pause with a mode change
            if (cut == 0 && i > 0 && $urandom_range(0, 199) == 0)
            begin
                wait_idle();
                reg_write(REG_ERODE, $urandom_range(0, 1));
                reg_write(REG_EIGHT, $urandom_range(0, 1));
            end
            push_item(FUNC_PIXEL, pick_pixel(style, density));
        end
        if (cut == 0)
        begin
            // drain: flush ticks or late pixels, whose values are dropped
            for (i = 0; i <= cols; i++)
            begin
                if ($urandom_range(0, 1) != 0)
                    push_item(FUNC_FLUSH, pixel_t'($urandom_range(0, 255)));
                else
                    push_item(FUNC_PIXEL, pixel_t'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 3) == 0)
                push_item(FUNC_FLUSH, pixel_t'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin : stimulus
        int  cols;
        int  rows;
        int  wr;
        int  hr;
        int  r;
        int  cut;
        bit  need_size;

        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        pix_in_ch.valid    <= 1'b0;
        pix_in_ch.func     <= FUNC_PIXEL;
        pix_in_ch.pixel_in <= '0;
        rst_n              <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed: 2x2 frame, sizes below range saturate to 2 ---
        reg_write(REG_WIDTH, 0);
        reg_write(REG_HEIGHT, 1);
        reg_write(REG_ERODE, 0);
        reg_write(REG_EIGHT, 1);
        push_item(FUNC_FLUSH, 8'hFF);       // flush before anything is ready
        push_item(FUNC_PIXEL, 8'd1);
        push_item(FUNC_PIXEL, 8'd0);
        push_item(FUNC_PIXEL, 8'd255);      // blank passes through, never counts
        push_item(FUNC_PIXEL, 8'd0);
        push_item(FUNC_PIXEL, 8'hAA);       // after frame end: acts as a flush
        push_item(FUNC_FLUSH, 8'h00);
        push_item(FUNC_FLUSH, 8'h55);
        push_item(FUNC_FLUSH, 8'h00);       // frame already done: no result

        // --- directed: 3x2 erosion, four-connected ---
        wait_idle();
        reg_write(REG_ERODE, 1);
        reg_write(REG_EIGHT, 0);
        reg_write(REG_WIDTH, 3);
        reg_write(REG_HEIGHT, 2);
        push_item(FUNC_PIXEL, 8'd1);
        push_item(FUNC_PIXEL, 8'd1);
        push_item(FUNC_PIXEL, 8'd0);
        push_item(FUNC_PIXEL, 8'h80);
        push_item(FUNC_PIXEL, 8'd1);
        push_item(FUNC_PIXEL, 8'h7F);
        repeat (4) push_item(FUNC_FLUSH, 8'h0F);

        // --- random frames, small sizes ---
        cols      = 3;
        rows      = 2;
        need_size = 1'b0;
        while (items_sent < ITEM_TARGET)
        begin
            wait_idle();
            if (need_size || $urandom_range(0, 3) != 0)
            begin
                r    = $urandom_range(0, 99);
                wr   = (r < 6) ? $urandom_range(0, 1) : (r < 14) ? 2 : $urandom_range(3, 12);
                r    = $urandom_range(0, 99);
                hr   = (r < 6) ? $urandom_range(0, 1) : (r < 14) ? 2 : $urandom_range(3, 8);
                cols = (wr < 2) ? 2 : wr;
                rows = (hr < 2) ? 2 : hr;
                reg_write(REG_WIDTH, wr);
                reg_write(REG_HEIGHT, hr);
            end
            if ($urandom_range(0, 1) != 0)
                reg_write(REG_ERODE, $urandom_range(0, 1));
            if ($urandom_range(0, 1) != 0)
                reg_write(REG_EIGHT, $urandom_range(0, 1));
            // now and then abandon a frame part-way; a size write restarts it
            cut = ($urandom_range(0, 99) < 8) ? $urandom_range(1, cols * rows - 1) : 0;
            stream_frame(cols, rows, $urandom_range(STY_BINARY, STY_FLAT), cut);
            need_size = (cut != 0);
        end

        // --- height above range saturates; part of a tall frame only ---
        wait_idle();
        reg_write(REG_WIDTH, 2);
        reg_write(REG_HEIGHT, 32'h1FFF);
        stream_frame(2, DEF_MAX_HEIGHT, STY_BINARY, 40);

        // --- widest frame: width above range saturates to the maximum;
        //     the first row and part of the second, enough for results ---
        wait_idle();
        reg_write(REG_WIDTH, 32'h7FF);
        reg_write(REG_HEIGHT, 0);
        reg_write(REG_ERODE, $urandom_range(0, 1));
        reg_write(REG_EIGHT, 1);
        stream_frame(DEF_MAX_WIDTH, 2, STY_BLANKS, WIDE_CUT);

        wait_idle();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[binary_erode_dilate_2d.f]
src/bed_pkg.sv
src/bed_if.sv
src/bed_line_buf.sv
src/bed_kernel.sv
src/binary_erode_dilate_2d.sv
src/bed_checker.sv
verif/bed_morph_checker.sv
verif/tb_binary_erode_dilate_2d.sv
